// ===== design/markup_token_lexer_macros.svh =====
// Assertion macros used by the lexer's port checker.
`ifndef MARKUP_TOKEN_LEXER_MACROS_SVH
`define MARKUP_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MTL_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication, disabled while in reset.
`define MTL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ===== design/mtl_pkg.sv =====
// Shared constants and types of the markup token lexer.
`default_nettype none

package mtl_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int WIDE_BITS         = 32;
    localparam int OUT_BITS          = 16;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] BYTE_AT_END = 8'hFF;

    localparam logic [2:0] TK_WORD   = 3'd0;
    localparam logic [2:0] TK_NUMBER = 3'd1;
    localparam logic [2:0] TK_OPEN   = 3'd2;
    localparam logic [2:0] TK_CLOSE  = 3'd3;
    localparam logic [2:0] TK_QUOTE  = 3'd4;
    localparam logic [2:0] TK_SLASH  = 3'd5;
    localparam logic [2:0] TK_END    = 3'd6;
    localparam logic [2:0] TK_ERROR  = 3'd7;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_MINUS    = 3'd2;
    localparam logic [2:0] ERR_LEAD_ZERO = 3'd3;
    localparam logic [2:0] ERR_NO_FRAC  = 3'd4;

    typedef struct packed {
        logic [2:0]          token_kind;
        logic [2:0]          error_code;
        logic [OUT_BITS-1:0] start_row;
        logic [OUT_BITS-1:0] start_col;
        logic [OUT_BITS-1:0] token_length;
        logic [7:0]          offending_byte;
        logic                last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

`default_nettype wire

// ===== design/mtl_if.sv =====
// Valid/ready channel interfaces for input bytes and result tokens.
`default_nettype none

interface mtl_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface mtl_token_if;
    import mtl_pkg::*;

    logic                valid;
    logic                ready;
    logic [2:0]          token_kind;
    logic [2:0]          error_code;
    logic [OUT_BITS-1:0] start_row;
    logic [OUT_BITS-1:0] start_col;
    logic [OUT_BITS-1:0] token_length;
    logic [7:0]          offending_byte;
    logic                last;

    modport source (
        output valid, output token_kind, output error_code, output start_row,
        output start_col, output token_length, output offending_byte, output last,
        input ready
    );
    modport sink (
        input valid, input token_kind, input error_code, input start_row,
        input start_col, input token_length, input offending_byte, input last,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/mtl_core.sv =====
// Lexer state machine: cursor, pending token and per-byte result decode.
`default_nettype none

module mtl_core #(
    parameter int POSITION_BITS = mtl_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = mtl_pkg::LENGTH_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  logic          kind,
    input  logic [7:0]    char_code,
    output mtl_pkg::push_t push
);
    import mtl_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_MINUS, M_ZERO, M_INT, M_DOT, M_FRAC, M_HALT
    } mode_t;

    typedef enum logic [2:0] {
        A_NONE, A_GROW, A_FAIL, A_IDLE, A_FINISH_IDLE, A_END
    } act_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_ONE = LENGTH_BITS'(1);
    localparam logic [OUT_BITS-1:0]      OUT_MAX = '1;

    function automatic logic [POSITION_BITS-1:0] pos_add(
        input logic [POSITION_BITS-1:0] a,
        input logic [LENGTH_BITS-1:0]   b
    );
        logic [WIDE_BITS:0] s;
        s = (WIDE_BITS+1)'(a) + (WIDE_BITS+1)'(b);
        pos_add = (s > (WIDE_BITS+1)'(POS_MAX)) ? POS_MAX : s[POSITION_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        clamp_pos = (w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_len(input logic [LENGTH_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        clamp_len = (w > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : w[OUT_BITS-1:0];
    endfunction

    function automatic res_t make_res(
        input logic [2:0]               k,
        input logic [2:0]               e,
        input logic [POSITION_BITS-1:0] r,
        input logic [POSITION_BITS-1:0] c,
        input logic [LENGTH_BITS-1:0]   l,
        input logic [7:0]               b
    );
        res_t t;
        t.token_kind     = k;
        t.error_code     = e;
        t.start_row      = clamp_pos(r);
        t.start_col      = clamp_pos(c);
        t.token_length   = clamp_len(l);
        t.offending_byte = b;
        t.last           = 1'b0;
        make_res = t;
    endfunction

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] row_reg, row_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [LENGTH_BITS-1:0]   len_reg, len_next;

    act_t       act;
    mode_t      grow_mode;
    logic [2:0] fail_err;
    logic [2:0] fin_kind;
    logic       pending;
    logic       do_finish;
    logic       digit_hit;
    logic       is_upper;

    logic [POSITION_BITS-1:0] col_fin;
    logic [POSITION_BITS-1:0] idle_base;
    logic [POSITION_BITS-1:0] col_inc;
    logic [POSITION_BITS-1:0] row_inc;
    logic [LENGTH_BITS-1:0]   len_inc;

    logic                     id_emit;
    logic [2:0]               id_kind;
    logic [2:0]               id_err;
    logic [LENGTH_BITS-1:0]   id_len;
    mode_t                    id_mode;
    logic                     id_start;
    logic [POSITION_BITS-1:0] id_col;
    logic [POSITION_BITS-1:0] id_row;

    res_t       fin_res;
    res_t       id_res;
    logic [1:0] n;

    assign digit_hit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_upper  = (char_code >= CH_UPA) && (char_code <= CH_UPZ);
    assign pending  = (mode_reg == M_WORD) || (mode_reg == M_ZERO) ||
                      (mode_reg == M_INT) || (mode_reg == M_FRAC);
    assign fin_kind = (mode_reg == M_WORD) ? TK_WORD : TK_NUMBER;
    assign len_inc  = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + LEN_ONE;
    assign col_fin  = pos_add(col_reg, len_reg);
    assign row_inc  = pos_add(row_reg, LEN_ONE);

    // What the current mode does with this word
    always_comb
    begin
        act       = A_NONE;
        grow_mode = mode_reg;
        fail_err  = ERR_NONE;
        if (fire && mode_reg != M_HALT) begin
            if (kind) begin
                if (mode_reg == M_MINUS) begin
                    act      = A_FAIL;
                    fail_err = ERR_MINUS;
                end else if (mode_reg == M_DOT) begin
                    act      = A_FAIL;
                    fail_err = ERR_NO_FRAC;
                end else begin
                    act = A_END;
                end
            end else begin
                unique case (mode_reg)
                    M_WORD:
                    begin
                        if (is_upper || char_code == CH_MINUS) begin
                            act = A_GROW;
                        end else begin
                            act = A_FINISH_IDLE;
                        end
                    end
                    M_MINUS:
                    begin
                        if (char_code == CH_ZERO) begin
                            act       = A_GROW;
                            grow_mode = M_ZERO;
                        end else if (digit_hit) begin
                            act       = A_GROW;
                            grow_mode = M_INT;
                        end else begin
                            act      = A_FAIL;
                            fail_err = ERR_MINUS;
                        end
                    end
                    M_ZERO:
                    begin
                        if (digit_hit) begin
                            act      = A_FAIL;
                            fail_err = ERR_LEAD_ZERO;
                        end else if (char_code == CH_DOT) begin
                            act       = A_GROW;
                            grow_mode = M_DOT;
                        end else begin
                            act = A_FINISH_IDLE;
                        end
                    end
                    M_INT:
                    begin
                        if (digit_hit) begin
                            act = A_GROW;
                        end else if (char_code == CH_DOT) begin
                            act       = A_GROW;
                            grow_mode = M_DOT;
                        end else begin
                            act = A_FINISH_IDLE;
                        end
                    end
                    M_DOT:
                    begin
                        if (digit_hit) begin
                            act       = A_GROW;
                            grow_mode = M_FRAC;
                        end else begin
                            act      = A_FAIL;
                            fail_err = ERR_NO_FRAC;
                        end
                    end
                    M_FRAC:
                    begin
                        if (digit_hit) begin
                            act = A_GROW;
                        end else begin
                            act = A_FINISH_IDLE;
                        end
                    end
                    default:
                    begin
                        act = A_IDLE;
                    end
                endcase
            end
        end
    end

    assign do_finish = pending && (act == A_FINISH_IDLE || act == A_END);
    assign idle_base = do_finish ? col_fin : col_reg;
    assign col_inc   = pos_add(idle_base, LEN_ONE);

    // Byte seen between tokens
    always_comb
    begin
        id_emit  = 1'b0;
        id_kind  = TK_ERROR;
        id_err   = ERR_NONE;
        id_len   = '0;
        id_mode  = M_IDLE;
        id_start = 1'b0;
        id_col   = idle_base;
        id_row   = row_reg;
        if (char_code == CH_SPACE) begin
            id_col = col_inc;
        end else if (char_code == CH_NL) begin
            id_row = row_inc;
            id_col = POS_ONE;
        end else if (char_code == CH_MINUS) begin
            id_start = 1'b1;
            id_mode  = M_MINUS;
        end else if (char_code == CH_ZERO) begin
            id_start = 1'b1;
            id_mode  = M_ZERO;
        end else if (digit_hit) begin
            id_start = 1'b1;
            id_mode  = M_INT;
        end else if (is_upper) begin
            id_start = 1'b1;
            id_mode  = M_WORD;
        end else if (char_code == CH_LT || char_code == CH_GT ||
                     char_code == CH_QUOTE || char_code == CH_SLASH) begin
            id_emit = 1'b1;
            id_len  = LEN_ONE;
            id_col  = col_inc;
            if (char_code == CH_LT) begin
                id_kind = TK_OPEN;
            end else if (char_code == CH_GT) begin
                id_kind = TK_CLOSE;
            end else if (char_code == CH_QUOTE) begin
                id_kind = TK_QUOTE;
            end else begin
                id_kind = TK_SLASH;
            end
        end else begin
            id_emit = 1'b1;
            id_err  = ERR_BAD_CHAR;
            id_mode = M_HALT;
        end
    end

    assign fin_res = make_res(fin_kind, ERR_NONE, row_reg, col_reg, len_reg, 8'd0);
    assign id_res  = make_res(id_kind, id_err, row_reg, idle_base, id_len,
                              (id_err == ERR_NONE) ? 8'd0 : char_code);

    // Next state and results
    always_comb
    begin
        mode_next   = mode_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        len_next    = len_reg;
        n           = 2'd0;
        push.first  = fin_res;
        push.second = id_res;
        case (act)
            A_GROW:
            begin
                mode_next = grow_mode;
                len_next  = len_inc;
            end
            A_FAIL:
            begin
                push.first = make_res(TK_ERROR, fail_err, row_reg, col_reg, '0,
                                      kind ? BYTE_AT_END : char_code);
                n          = 2'd1;
                mode_next  = M_HALT;
            end
            A_IDLE:
            begin
                push.first = id_res;
                n          = id_emit ? 2'd1 : 2'd0;
                mode_next  = id_mode;
                row_next   = id_row;
                col_next   = id_col;
                len_next   = id_start ? LEN_ONE : '0;
            end
            A_FINISH_IDLE:
            begin
                n         = id_emit ? 2'd2 : 2'd1;
                mode_next = id_mode;
                row_next  = id_row;
                col_next  = id_col;
                len_next  = id_start ? LEN_ONE : '0;
            end
            A_END:
            begin
                mode_next = M_HALT;
                len_next  = '0;
                if (do_finish) begin
                    push.second = make_res(TK_END, ERR_NONE, row_reg, col_fin, '0, 8'd0);
                    n           = 2'd2;
                    col_next    = col_fin;
                end else begin
                    push.first = make_res(TK_END, ERR_NONE, row_reg, col_reg, '0, 8'd0);
                    n          = 2'd1;
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase
        push.first.last  = (n == 2'd1);
        push.second.last = 1'b1;
        push.count       = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            row_reg  <= POS_ONE;
            col_reg  <= POS_ONE;
            len_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mtl_res_fifo.sv =====
// Result queue: takes up to two results per cycle, gives one per cycle on pop.
`default_nettype none

module mtl_res_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  mtl_pkg::push_t push,
    input  logic           pop,
    output logic           room,
    output logic           valid,
    output mtl_pkg::res_t  head
);
    import mtl_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    res_t                mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PTR_BITS-1:0] wr_plus;
    logic                do_pop;

    assign wr_plus = wr_reg + PTR_BITS'(1);
    assign do_pop  = pop && valid;
    assign valid   = (cnt_reg != '0);
    assign room    = (cnt_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign head    = mem_reg[rd_reg];

    assign wr_next  = wr_reg + PTR_BITS'(push.count);
    assign rd_next  = do_pop ? rd_reg + PTR_BITS'(1) : rd_reg;
    assign cnt_next = cnt_reg + CNT_BITS'(push.count) - CNT_BITS'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem_reg[wr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/markup_token_lexer.sv =====
// Markup token lexer: one input word per cycle while the queue has room, one token
// word out per cycle while the receiver is ready. An accepted byte sits in an input
// register, the lexer core decodes it against the mode, cursor and pending length in
// that same cycle and writes its zero, one or two results into a four-entry result
// queue. The core takes a byte only while the queue has two free entries, so one
// byte per cycle is sustained as long as results are drained about as fast; a byte
// that closes a token and also makes one (e.g. "AB<") yields two results. After an
// end or error word the block swallows every later input word silently until reset.
`default_nettype none

module markup_token_lexer #(
    parameter int POSITION_BITS = mtl_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = mtl_pkg::LENGTH_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mtl_char_if.sink     chars,
    mtl_token_if.source  tokens
);
    import mtl_pkg::*;

    logic       stage_valid_reg, stage_valid_next;
    logic       stage_kind_reg;
    logic [7:0] stage_char_reg;
    logic       accept;
    logic       fire;
    logic       room;
    logic       res_valid;
    push_t      push;
    res_t       head;

    assign fire         = stage_valid_reg && room;
    assign chars.ready  = !stage_valid_reg || fire;
    assign accept       = chars.valid && chars.ready;
    assign stage_valid_next = accept ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            stage_kind_reg <= chars.kind;
            stage_char_reg <= chars.char_code;
        end
    end

    mtl_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (stage_kind_reg),
        .char_code (stage_char_reg),
        .push      (push)
    );

    mtl_res_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (tokens.ready),
        .room  (room),
        .valid (res_valid),
        .head  (head)
    );

    assign tokens.valid          = res_valid;
    assign tokens.token_kind     = head.token_kind;
    assign tokens.error_code     = head.error_code;
    assign tokens.start_row      = head.start_row;
    assign tokens.start_col      = head.start_col;
    assign tokens.token_length   = head.token_length;
    assign tokens.offending_byte = head.offending_byte;
    assign tokens.last           = head.last;

endmodule

`default_nettype wire

// ===== design/mtl_checker.sv =====
// Port-level checks of the lexer's token channel, bound to the top level.
`default_nettype none

`include "markup_token_lexer_macros.svh"

module mtl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [2:0]  token_kind,
    input logic [2:0]  error_code,
    input logic [15:0] start_row,
    input logic [15:0] start_col,
    input logic [15:0] token_length,
    input logic [7:0]  offending_byte,
    input logic        last
);
    import mtl_pkg::*;

    `MTL_ASSERT_NEXT(a_valid_holds, clk, rst_n, valid && !ready, valid)
    `MTL_ASSERT_NEXT(a_word_holds, clk, rst_n, valid && !ready, $stable(token_kind) && $stable(error_code) && $stable(start_row) && $stable(start_col) && $stable(token_length) && $stable(offending_byte) && $stable(last))
    `MTL_ASSERT_IMPLY(a_clean_token, clk, rst_n, valid && token_kind != TK_ERROR, error_code == ERR_NONE && offending_byte == 8'd0)
    `MTL_ASSERT_IMPLY(a_final_last, clk, rst_n, valid && (token_kind == TK_END || token_kind == TK_ERROR), last)
    `MTL_ASSERT_NEXT(a_quiet_after, clk, rst_n, valid && ready && (token_kind == TK_END || token_kind == TK_ERROR), !valid)

endmodule

bind markup_token_lexer mtl_checker u_mtl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (tokens.valid),
    .ready          (tokens.ready),
    .token_kind     (tokens.token_kind),
    .error_code     (tokens.error_code),
    .start_row      (tokens.start_row),
    .start_col      (tokens.start_col),
    .token_length   (tokens.token_length),
    .offending_byte (tokens.offending_byte),
    .last           (tokens.last)
);

`default_nettype wire

// ===== tb/markup_token_lexer_checker.sv =====
// Checker for the markup token lexer: predicts token words from accepted input and compares.
module markup_token_lexer_checker (
    input  logic clk,
    input  logic rst_n,
    mtl_char_if  chars,
    mtl_token_if tokens,
    output int   fail_count,
    output int   expected_left,
    output int   results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtl_pkg::*;

    localparam logic [31:0] POS_MAX = (32'd1 << POSITION_BITS_DEF) - 32'd1;
    localparam logic [31:0] LEN_MAX = (32'd1 << LENGTH_BITS_DEF) - 32'd1;

    typedef enum logic [3:0] {
        LEX_IDLE,
        LEX_WORD,
        LEX_MINUS,
        LEX_ZERO,
        LEX_INT,
        LEX_DOT,
        LEX_FRAC,
        LEX_HALT
    } lex_mode_e;

    lex_mode_e   mode;
    logic [31:0] cur_row;
    logic [31:0] cur_col;
    logic [31:0] pend_len;
    res_t        step_res [2];
    int          step_n;
    res_t        token_q [$];

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] mx);
        if (a >= mx || b >= mx - a)
        begin
            return mx;
        end
        return a + b;
    endfunction

    function automatic logic digit_chk(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return c >= CH_UPA && c <= CH_UPZ;
    endfunction

    // Token words carry the cursor, which holds the token start while one is pending.
    function void emit(input logic [2:0] tk, input logic [2:0] ec, input logic [31:0] len,
                       input logic [7:0] ob);
        step_res[step_n] = '{token_kind: tk, error_code: ec,
                             start_row: cur_row[OUT_BITS-1:0],
                             start_col: cur_col[OUT_BITS-1:0],
                             token_length: len[OUT_BITS-1:0],
                             offending_byte: ob, last: 1'b0};
        step_n = step_n + 1;
    endfunction

    function void fail_with(input logic [2:0] ec, input logic [7:0] ob);
        emit(TK_ERROR, ec, 32'd0, ob);
        mode = LEX_HALT;
    endfunction

    function void close_token(input logic [2:0] tk);
        emit(tk, ERR_NONE, pend_len, 8'd0);
        cur_col = sat_add(cur_col, pend_len, POS_MAX);
        pend_len = 32'd0;
        mode = LEX_IDLE;
    endfunction

    function void open_token(input lex_mode_e m);
        mode = m;
        pend_len = 32'd1;
    endfunction

    function void extend_token(input lex_mode_e m);
        mode = m;
        pend_len = sat_add(pend_len, 32'd1, LEN_MAX);
    endfunction

    function void sign_token(input logic [2:0] tk);
        emit(tk, ERR_NONE, 32'd1, 8'd0);
        cur_col = sat_add(cur_col, 32'd1, POS_MAX);
    endfunction

    function void lex_between(input logic [7:0] c);
        case (c)
            CH_SPACE: cur_col = sat_add(cur_col, 32'd1, POS_MAX);
            CH_NL:
            begin
                cur_row = sat_add(cur_row, 32'd1, POS_MAX);
                cur_col = 32'd1;
            end
            CH_MINUS: open_token(LEX_MINUS);
            CH_ZERO:  open_token(LEX_ZERO);
            CH_LT:    sign_token(TK_OPEN);
            CH_GT:    sign_token(TK_CLOSE);
            CH_QUOTE: sign_token(TK_QUOTE);
            CH_SLASH: sign_token(TK_SLASH);
            default:
            begin
                if (digit_chk(c))
                begin
                    open_token(LEX_INT);
                end
                else if (is_upper(c))
                begin
                    open_token(LEX_WORD);
                end
                else
                begin
                    fail_with(ERR_BAD_CHAR, c);
                end
            end
        endcase
    endfunction

    function void lex_step(input logic is_end, input logic [7:0] c);
        res_t r;
        step_n = 0;
        if (mode != LEX_HALT)
        begin
            if (is_end)
            begin
                if (mode == LEX_MINUS)
                begin
                    fail_with(ERR_MINUS, BYTE_AT_END);
                end
                else if (mode == LEX_DOT)
                begin
                    fail_with(ERR_NO_FRAC, BYTE_AT_END);
                end
                else
                begin
                    if (mode == LEX_WORD)
                    begin
                        close_token(TK_WORD);
                    end
                    else if (mode != LEX_IDLE)
                    begin
                        close_token(TK_NUMBER);
                    end
                    emit(TK_END, ERR_NONE, 32'd0, 8'd0);
                    mode = LEX_HALT;
                end
            end
            else
            begin
                case (mode)
                    LEX_WORD:
                    begin
                        if (is_upper(c) || c == CH_MINUS)
                        begin
                            extend_token(LEX_WORD);
                        end
                        else
                        begin
                            close_token(TK_WORD);
                            lex_between(c);
                        end
                    end
                    LEX_MINUS:
                    begin
                        if (c == CH_ZERO)
                        begin
                            extend_token(LEX_ZERO);
                        end
                        else if (digit_chk(c))
                        begin
                            extend_token(LEX_INT);
                        end
                        else
                        begin
                            fail_with(ERR_MINUS, c);
                        end
                    end
                    LEX_ZERO:
                    begin
                        if (digit_chk(c))
                        begin
                            fail_with(ERR_LEAD_ZERO, c);
                        end
                        else if (c == CH_DOT)
                        begin
                            extend_token(LEX_DOT);
                        end
                        else
                        begin
                            close_token(TK_NUMBER);
                            lex_between(c);
                        end
                    end
                    LEX_INT:
                    begin
                        if (digit_chk(c))
                        begin
                            extend_token(LEX_INT);
                        end
                        else if (c == CH_DOT)
                        begin
                            extend_token(LEX_DOT);
                        end
                        else
                        begin
                            close_token(TK_NUMBER);
                            lex_between(c);
                        end
                    end
                    LEX_DOT:
                    begin
                        if (digit_chk(c))
                        begin
                            extend_token(LEX_FRAC);
                        end
                        else
                        begin
                            fail_with(ERR_NO_FRAC, c);
                        end
                    end
                    LEX_FRAC:
                    begin
                        if (digit_chk(c))
                        begin
                            extend_token(LEX_FRAC);
                        end
                        else
                        begin
                            close_token(TK_NUMBER);
                            lex_between(c);
                        end
                    end
                    default: lex_between(c);
                endcase
            end
        end
        for (int i = 0; i < step_n; i++)
        begin
            r = step_res[i];
            r.last = (i == step_n - 1);
            token_q = {token_q, r};
        end
    endfunction

    function automatic int field_diff(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_res;
        int   bad;
        if (!rst_n)
        begin
            mode            = LEX_IDLE;
            cur_row         = 32'd1;
            cur_col         = 32'd1;
            pend_len        = 32'd0;
            token_q.delete();
            fail_count      = 0;
            results_checked = 0;
            expected_left   = 0;
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                lex_step(chars.kind, chars.char_code);
            end
            if (tokens.valid && tokens.ready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("token word of kind %0d with nothing predicted", tokens.token_kind);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_res = token_q.pop_front();
                    bad = field_diff("token_kind", 16'(exp_res.token_kind),
                                     16'(tokens.token_kind))
                        + field_diff("error_code", 16'(exp_res.error_code),
                                     16'(tokens.error_code))
                        + field_diff("start_row", exp_res.start_row, tokens.start_row)
                        + field_diff("start_col", exp_res.start_col, tokens.start_col)
                        + field_diff("token_length", exp_res.token_length, tokens.token_length)
                        + field_diff("offending_byte", 16'(exp_res.offending_byte),
                                     16'(tokens.offending_byte))
                        + field_diff("last", 16'(exp_res.last), 16'(tokens.last));
                    if (bad != 0)
                    begin
                        fail_count = fail_count + 1;
                    end
                    results_checked = results_checked + 1;
                end
            end
            expected_left = token_q.size();
        end
    end

endmodule

// ===== tb/markup_token_lexer_tb.sv =====
// Testbench top for the markup token lexer: clock, reset, stimulus and verdict.
module markup_token_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtl_pkg::*;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_END     = 1'b1;
    localparam int   RANDOM_ITEMS = 900;
    localparam int   LONG_HOLD    = 200;
    localparam int   DRAIN_CYCLES = 20;

    typedef enum int {
        END_IDLE,
        END_WORD,
        END_NUMBER,
        END_ZERO,
        END_FRAC,
        END_MINUS,
        END_DOT,
        BAD_IDLE,
        BAD_AFTER_WORD,
        MINUS_NO_DIGIT,
        ZERO_DIGIT,
        DOT_NO_DIGIT,
        DOT_AFTER_FRAC
    } finale_e;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    bit      src_idle_en  = 1'b1;
    bit      sink_idle_en = 1'b1;
    bit      hold_req     = 1'b0;
    bit      after_number = 1'b0;
    int      items_sent   = 0;
    int      fail_count;
    int      expected_left;
    int      results_checked;
    finale_e finale;

    mtl_char_if  chars_if ();
    mtl_token_if tokens_if ();

    markup_token_lexer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .tokens (tokens_if)
    );

    markup_token_lexer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .chars           (chars_if),
        .tokens          (tokens_if),
        .fail_count      (fail_count),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_bad_byte();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: return 8'hFF;
            1: return 8'h00;
            2: return CH_DOT;
            default: ;
        endcase
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_NL || c == CH_MINUS || c == CH_LT || c == CH_GT
               || c == CH_QUOTE || c == CH_SLASH || (c >= CH_ZERO && c <= CH_NINE)
               || (c >= CH_UPA && c <= CH_UPZ));
        return c;
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    // Returns right after the accepting edge; the next call or go_quiet settles valid.
    task automatic send_word(input logic k, input logic [7:0] c);
        int gap;
        @(negedge clk);
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.kind      <= k;
        chars_if.char_code <= c;
        do
            @(posedge clk);
        while (!chars_if.ready);
        items_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send_word(KIND_CHAR, c);
    endtask

    task automatic go_quiet();
        @(negedge clk);
        chars_if.valid <= 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i]);
        end
    endtask

    task automatic send_digit(input int lo);
        send_char(CH_ZERO + 8'($urandom_range(lo, 9)));
    endtask

    task automatic send_blanks();
        repeat ($urandom_range(1, 3))
        begin
            send_char(($urandom_range(0, 3) == 0) ? CH_NL : CH_SPACE);
        end
        after_number = 1'b0;
    endtask

    task automatic send_rand_word();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        send_char(CH_UPA + 8'($urandom_range(0, 25)));
        repeat (len - 1)
        begin
            send_char(($urandom_range(0, 4) == 0) ? CH_MINUS
                                                  : CH_UPA + 8'($urandom_range(0, 25)));
        end
        after_number = 1'b0;
    endtask

    // A number right after a digit-led number would merge or break, so split them.
    task automatic send_rand_number();
        logic neg;
        neg = ($urandom_range(0, 3) == 0);
        if (after_number && !neg)
        begin
            send_char(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_NL);
        end
        if (neg)
        begin
            send_char(CH_MINUS);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_char(CH_ZERO);
        end
        else
        begin
            send_digit(1);
            repeat ($urandom_range(0, 4)) send_digit(0);
        end
        if ($urandom_range(0, 9) < 4)
        begin
            send_char(CH_DOT);
            repeat ($urandom_range(1, 4)) send_digit(0);
        end
        after_number = 1'b1;
    endtask

    task automatic send_rand_sign();
        case ($urandom_range(0, 3))
            0:       send_char(CH_LT);
            1:       send_char(CH_GT);
            2:       send_char(CH_QUOTE);
            default: send_char(CH_SLASH);
        endcase
        after_number = 1'b0;
    endtask

    task automatic send_finale(input finale_e f);
        send_char(CH_SPACE);
        case (f)
            END_WORD:       send_text("QR");
            END_NUMBER:     send_text("42");
            END_ZERO:       send_char(CH_ZERO);
            END_FRAC:       send_text("1.5");
            END_MINUS:      send_char(CH_MINUS);
            END_DOT:        send_text("7.");
            BAD_IDLE:       send_char(pick_bad_byte());
            BAD_AFTER_WORD:
            begin
                send_char(CH_UPA + 8'($urandom_range(0, 25)));
                send_char(pick_bad_byte());
            end
            MINUS_NO_DIGIT:
            begin
                send_char(CH_MINUS);
                send_char(pick_non_digit());
            end
            ZERO_DIGIT:
            begin
                send_char(CH_ZERO);
                send_digit(0);
            end
            DOT_NO_DIGIT:
            begin
                send_text("5.");
                send_char(pick_non_digit());
            end
            DOT_AFTER_FRAC: send_text("2.5.");
            default: ;
        endcase
        send_word(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int  random_stop;
        int  pick;
        bit  hold_done;
        bit  pause_done;
        bit  saved_idle;
        chars_if.valid     = 1'b0;
        chars_if.kind      = KIND_CHAR;
        chars_if.char_code = 8'd0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every sign, word with dash, number forms, dash ending a number, zero forms
        send_text("A-Z<-10.25-3 0.5 0>9\n\"/");

        random_stop = items_sent + RANDOM_ITEMS;
        while (items_sent < random_stop)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (!hold_done && items_sent >= random_stop - 650)
            begin
                // receiver holds off while bytes keep coming, filling the result queue
                hold_done   = 1'b1;
                hold_req    = 1'b1;
                saved_idle  = src_idle_en;
                src_idle_en = 1'b0;
                repeat (24) send_char(CH_LT);
                src_idle_en  = saved_idle;
                after_number = 1'b0;
            end
            else if (!pause_done && items_sent >= random_stop - 350)
            begin
                pause_done = 1'b1;
                go_quiet();
                while (expected_left != 0) @(negedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    send_rand_word();
                end
                else if (pick < 65)
                begin
                    send_rand_number();
                end
                else if (pick < 85)
                begin
                    send_rand_sign();
                end
                else
                begin
                    send_blanks();
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_blanks();
                end
            end
        end

        // one closing case picked by the seed
        send_text("<X");
        finale = finale_e'($urandom_range(0, 12));
        send_finale(finale);

        // halted: these must produce nothing
        send_word(KIND_CHAR, 8'h00);
        send_word(KIND_CHAR, 8'hFF);
        send_word(KIND_CHAR, CH_LT);
        send_word(KIND_END, 8'h00);
        repeat (12) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        go_quiet();

        while (expected_left != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d input words sent, %0d token words checked.",
                 items_sent, results_checked);
        $display("Covered signs, word and number forms, a %0d-cycle %s",
                 LONG_HOLD, $sformatf("output hold-off, a drain pause, closing case %s.",
                                      finale.name()));
        if (fail_count == 0 && expected_left == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        tokens_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                tokens_if.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD - 1;
                tokens_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                tokens_if.ready <= 1'b0;
            end
            else
            begin
                tokens_if.ready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 99) < 30)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $error("timeout: token words still outstanding or input stuck");
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/mtl_pkg.sv
design/mtl_if.sv
design/mtl_core.sv
design/mtl_res_fifo.sv
design/markup_token_lexer.sv
design/mtl_checker.sv
tb/markup_token_lexer_checker.sv
tb/markup_token_lexer_tb.sv
